@@ design/nts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA time sentence timestamp package
// Shared constants, the result record and helpers for the timestamp block.
// ----------------------------------------------------------------------------
package nts_pkg;

	localparam int unsigned NUM_DIGITS = 6;
	localparam logic [2:0]  SLOT_MAX   = 3'd7;

	localparam logic [7:0] CHAR_G     = 8'h47;
	localparam logic [7:0] CHAR_P     = 8'h50;
	localparam logic [7:0] CHAR_C     = 8'h43;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	localparam logic [1:0] COMMAS_FIELD = 2'd1;
	localparam logic [1:0] COMMAS_END   = 2'd2;

	localparam logic [31:0] MS_PER_HOUR   = 32'd3600000;
	localparam logic [31:0] MS_PER_MINUTE = 32'd60000;
	localparam logic [31:0] MS_PER_SECOND = 32'd1000;

	// Time fields of a finished sentence, each as a two-digit value.
	typedef struct packed {
		logic       emit;
		logic [6:0] hh;
		logic [6:0] mm;
		logic [6:0] ss;
	} nts_emit_t;

	function automatic logic [6:0] two_digit(input logic [3:0] tens, input logic [3:0] ones);
		logic [6:0] t;
		begin
			t = {3'b000, tens};
			two_digit = (t << 3) + (t << 1) + {3'b000, ones};
		end
	endfunction

endpackage

@@ design/nts_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA time sentence parser
// Header match, comma counting and the digit store of the time field.
// ----------------------------------------------------------------------------
module nts_parser import nts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] rx_byte,
	output nts_emit_t  result
);

	logic       seen_g_q, seen_p_q, header_armed_q;
	logic [1:0] comma_count_q;
	logic [2:0] digit_slot_q;
	logic [7:0] time_digits_q [NUM_DIGITS];

	logic       is_comma, is_dot;
	logic       seen_g_n, seen_p_n, armed_n;
	logic [1:0] comma_count_n;
	logic       store_digit, sentence_end;
	logic [7:0] digit_value;
	logic       nonzero, all_valid;

	assign is_comma = (rx_byte == CHAR_COMMA);
	assign is_dot   = (rx_byte == CHAR_DOT);

	assign seen_g_n      = seen_g_q | (rx_byte == CHAR_G);
	assign seen_p_n      = seen_p_q | ((rx_byte == CHAR_P) && seen_g_q);
	assign armed_n       = header_armed_q | ((rx_byte == CHAR_C) && seen_p_q);
	assign comma_count_n = is_comma ? comma_count_q + 2'd1 : comma_count_q;
	assign store_digit   = armed_n && (comma_count_n == COMMAS_FIELD) && !is_comma && !is_dot;
	assign sentence_end  = armed_n && (comma_count_n == COMMAS_END);
	assign digit_value   = rx_byte - CHAR_ZERO;

	always_comb begin
		nonzero   = 1'b0;
		all_valid = 1'b1;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (time_digits_q[i] >= 8'd10) begin
				all_valid = 1'b0;
			end
			if (i >= 2 && time_digits_q[i] != 8'd0) begin
				nonzero = 1'b1;
			end
		end
	end

	assign result.emit = sentence_end && nonzero && all_valid;
	assign result.hh   = two_digit(time_digits_q[0][3:0], time_digits_q[1][3:0]);
	assign result.mm   = two_digit(time_digits_q[2][3:0], time_digits_q[3][3:0]);
	assign result.ss   = two_digit(time_digits_q[4][3:0], time_digits_q[5][3:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_g_q       <= 1'b0;
			seen_p_q       <= 1'b0;
			header_armed_q <= 1'b0;
			comma_count_q  <= 2'd0;
			digit_slot_q   <= 3'd0;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				time_digits_q[i] <= 8'd0;
			end
		end else if (fire) begin
			if (sentence_end) begin
				// The second comma closes the sentence, valid or not.
				seen_g_q       <= 1'b0;
				seen_p_q       <= 1'b0;
				header_armed_q <= 1'b0;
				comma_count_q  <= 2'd0;
				digit_slot_q   <= 3'd0;
				for (int i = 0; i < NUM_DIGITS; i++) begin
					time_digits_q[i] <= 8'd0;
				end
			end else begin
				seen_g_q       <= seen_g_n;
				seen_p_q       <= seen_p_n;
				header_armed_q <= armed_n;
				if (armed_n) begin
					comma_count_q <= comma_count_n;
				end
				if (store_digit) begin
					for (int i = 0; i < NUM_DIGITS; i++) begin
						if (digit_slot_q == 3'(i)) begin
							time_digits_q[i] <= digit_value;
						end
					end
					if (digit_slot_q != SLOT_MAX) begin
						digit_slot_q <= digit_slot_q + 3'd1;
					end
				end
			end
		end
	end

endmodule

@@ design/nts_time_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA time of day calculator
// Converts hours, minutes and seconds to milliseconds and adds the PPS offset.
// ----------------------------------------------------------------------------
module nts_time_calc import nts_pkg::*; (
	input  logic [6:0]  hh,
	input  logic [6:0]  mm,
	input  logic [6:0]  ss,
	input  logic [31:0] pps_offset,
	output logic [31:0] time_of_day_ms
);

	logic [31:0] hour_ms, minute_ms, second_ms;

	assign hour_ms        = {25'd0, hh} * MS_PER_HOUR;
	assign minute_ms      = {25'd0, mm} * MS_PER_MINUTE;
	assign second_ms      = {25'd0, ss} * MS_PER_SECOND;
	assign time_of_day_ms = hour_ms + minute_ms + second_ms + pps_offset;

endmodule

@@ design/nmea_time_sentence_timestamp_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA time sentence timestamp
// Parses GPS receiver bytes and reports the UTC time of day in milliseconds.
// ----------------------------------------------------------------------------
// After the closing comma is accepted, its result passes through the parse register
// and then the output register, where it is valid.
// Throughput: one byte per cycle unless a finished sentence waits on a full parse
// register; the parse stage updates the header and digit state with each byte.
// Reset: arst_n clears all parser state, the digit store and all valid flags.
module nmea_time_sentence_timestamp_top import nts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // rx_byte[7:0], tick_now[39:8], pps_tick[71:40]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // time_of_day_ms[31:0], tick_at_update[63:32]
);

	logic        s1_valid_q;
	logic [7:0]  rx_byte_s1;
	logic [31:0] tick_now_s1, pps_tick_s1;

	logic        s2_valid_q;
	logic [6:0]  hh_s2, mm_s2, ss_s2;
	logic [31:0] offset_s2, tick_s2;

	logic        out_valid_q;
	logic [31:0] time_ms_q, tick_q;

	nts_emit_t   parse;
	logic        emit;
	logic        out_free, s2_free, s1_fire, s1_free;
	logic [31:0] time_ms;

	assign emit     = s1_valid_q && parse.emit;
	assign out_free = !out_valid_q || m_axis_tready;
	assign s2_free  = !s2_valid_q || out_free;
	assign s1_fire  = s1_valid_q && (!parse.emit || s2_free);
	assign s1_free  = !s1_valid_q || s1_fire;

	assign s_axis_tready = s1_free;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {tick_q, time_ms_q};

	nts_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (s1_fire),
		.rx_byte (rx_byte_s1),
		.result  (parse)
	);

	nts_time_calc u_calc (
		.hh             (hh_s2),
		.mm             (mm_s2),
		.ss             (ss_s2),
		.pps_offset     (offset_s2),
		.time_of_day_ms (time_ms)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid_q <= s_axis_tvalid;
			end
			if (s2_free) begin
				s2_valid_q <= s1_fire && emit;
			end
			if (out_free) begin
				out_valid_q <= s2_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			rx_byte_s1  <= s_axis_tdata[7:0];
			tick_now_s1 <= s_axis_tdata[39:8];
			pps_tick_s1 <= s_axis_tdata[71:40];
		end
		if (s2_free) begin
			hh_s2     <= parse.hh;
			mm_s2     <= parse.mm;
			ss_s2     <= parse.ss;
			offset_s2 <= tick_now_s1 - pps_tick_s1;
			tick_s2   <= tick_now_s1;
		end
		if (out_free) begin
			time_ms_q <= time_ms;
			tick_q    <= tick_s2;
		end
	end

	// A finished sentence that fires must reach the parse register.
	assert property (@(posedge clk) disable iff (!arst_n) s1_fire && emit |=> s2_valid_q)
		else $error("parsed time request lost before the parse register");

	// Input back-pressure only when every stage is full and the output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> s1_valid_q && s2_valid_q && out_valid_q && !m_axis_tready)
		else $error("input stalled while the pipeline had room");

	// A new result can only come from a valid parse register.
	assert property (@(posedge clk) disable iff (!arst_n) $rose(m_axis_tvalid) |-> $past(s2_valid_q))
		else $error("result request appeared without a parsed time");

endmodule

@@ bench/nmea_time_sentence_timestamp_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA time sentence timestamp testbench
// Feeds GPS receiver bytes with tick values through the stream input. Starts
// with a short table of sentences, then sends random sentences, broken
// sentences and line noise. An internal parser model or the table gives each stamp,
// and each delivered result is compared with the oldest expectation. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module nmea_time_sentence_timestamp_top_test;
	import nts_pkg::*;

	localparam int ITEM_TARGET    = 1750;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PRINT_LIMIT    = 40;

	typedef enum logic [1:0] {
		ITEM_PREDICTED,
		ITEM_SILENT,
		ITEM_STAMPED
	} item_kind_t;

	typedef struct packed {
		logic [31:0] time_ms;
		logic [31:0] tick;
	} stamp_t;

	typedef struct {
		string       text;
		logic [7:0]  raw;
		logic [31:0] now;
		logic [31:0] pps;
		item_kind_t  kind;
		stamp_t      typed;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;  // rx_byte[7:0], tick_now[39:8], pps_tick[71:40]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;  // time_of_day_ms[31:0], tick_at_update[63:32]

	// Kind and typed stamp of the request currently on the input.
	item_kind_t item_kind;
	stamp_t     item_typed;

	// Parser model state.
	logic       gps_seen_g;
	logic       gps_seen_p;
	logic       gps_armed;
	logic [1:0] field_commas;
	logic [2:0] digit_slot;
	logic [7:0] time_digits [NUM_DIGITS];

	stamp_t     expected_stamps [$];
	logic [7:0] sentence_q [$];
	int         mismatches;
	int         bytes_sent;
	logic       no_gaps;
	logic       rx_hold_req;

	// A raw row (empty text) sends its single byte. A stamped row expects its
	// stamp on the last byte and nothing before it.
	dir_row_t directed_rows [6] = '{
		'{"", 8'h00, 32'h0000_0000, 32'h0000_0000, ITEM_SILENT, '0},
		'{"GPC,235959,", 8'h00, 32'hFFFF_FFFF, 32'h0000_0000, ITEM_STAMPED,
			'{32'd86398999, 32'hFFFF_FFFF}},
		'{"GxPC,12.34567", 8'h00, 32'h1234_5678, 32'h0000_0100, ITEM_PREDICTED, '0},
		'{"", 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF, ITEM_PREDICTED, '0},
		'{",", 8'h00, 32'h8000_0000, 32'h0000_0001, ITEM_STAMPED,
			'{32'd2192779647, 32'h8000_0000}},
		'{"GPC,12,", 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ITEM_SILENT, '0}
	};

	nmea_time_sentence_timestamp_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_LIMIT) begin
			$display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
		end
		mismatches++;
	endtask

	function automatic void clear_parser();
		gps_seen_g   = 1'b0;
		gps_seen_p   = 1'b0;
		gps_armed    = 1'b0;
		field_commas = '0;
		digit_slot   = '0;
		foreach (time_digits[i]) time_digits[i] = 8'd0;
	endfunction

	// Advances the parser model by one byte and returns the stamp it emits.
	function automatic void advance_parser(input logic [7:0] c, input logic [31:0] now,
			input logic [31:0] pps, output logic emit, output logic [31:0] time_ms);
		logic        nonzero;
		logic        valid;
		logic [31:0] hours;
		logic [31:0] minutes;
		logic [31:0] seconds;
		emit    = 1'b0;
		time_ms = '0;
		if (c == CHAR_G) gps_seen_g = 1'b1;
		if (c == CHAR_P && gps_seen_g) gps_seen_p = 1'b1;
		if (c == CHAR_C && gps_seen_p) gps_armed = 1'b1;
		if (gps_armed) begin
			if (c == CHAR_COMMA) field_commas = field_commas + 2'd1;
			if (field_commas == COMMAS_FIELD && c != CHAR_COMMA && c != CHAR_DOT) begin
				if (digit_slot < NUM_DIGITS) time_digits[digit_slot] = c - CHAR_ZERO;
				if (digit_slot < SLOT_MAX) digit_slot = digit_slot + 3'd1;
			end
			if (field_commas == COMMAS_END) begin
				nonzero = |{time_digits[2], time_digits[3], time_digits[4], time_digits[5]};
				valid = 1'b1;
				foreach (time_digits[i]) begin
					if (time_digits[i] >= 8'd10) valid = 1'b0;
				end
				if (nonzero && valid) begin
					hours   = time_digits[0] * 10 + time_digits[1];
					minutes = time_digits[2] * 10 + time_digits[3];
					seconds = time_digits[4] * 10 + time_digits[5];
					time_ms = hours * MS_PER_HOUR + minutes * MS_PER_MINUTE
						+ seconds * MS_PER_SECOND + (now - pps);
					emit = 1'b1;
				end
				clear_parser();
			end
		end
	endfunction

	// Checks delivered stamps first, then predicts from the accepted byte, so a
	// stamp can never be matched against a request of the same edge.
	always @(posedge clk) begin : scoreboard
		stamp_t      got;
		stamp_t      want;
		logic        emit;
		logic [31:0] time_ms;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				got.time_ms = m_axis_tdata[31:0];
				got.tick    = m_axis_tdata[63:32];
				if (expected_stamps.size() == 0) begin
					report_mismatch("stamp with none pending", got.time_ms, '0);
				end else begin
					want = expected_stamps.pop_front();
					if (got.time_ms != want.time_ms)
						report_mismatch("time_of_day_ms", got.time_ms, want.time_ms);
					if (got.tick != want.tick)
						report_mismatch("tick_at_update", got.tick, want.tick);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				advance_parser(s_axis_tdata[7:0], s_axis_tdata[39:8], s_axis_tdata[71:40],
					emit, time_ms);
				case (item_kind)
					ITEM_PREDICTED: begin
						if (emit) expected_stamps.push_back('{time_ms, s_axis_tdata[39:8]});
					end
					ITEM_STAMPED: begin
						expected_stamps.push_back(item_typed);
					end
					default: begin
					end
				endcase
			end
		end
	end

	task automatic send_byte(input logic [7:0] c, input logic [31:0] now,
			input logic [31:0] pps, input item_kind_t kind, input stamp_t typed);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {pps, now, c};
		item_kind     <= kind;
		item_typed    <= typed;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
	endtask

	// Builds one random sentence: mostly well formed with random time content,
	// the rest line noise or a sentence that never reaches its closing comma.
	task automatic build_sentence();
		int         mode;
		int         style;
		int         n_digits;
		int         odd_pos;
		logic [7:0] odd_char;
		logic [3:0] digits [NUM_DIGITS];
		string      header;
		header = "$GPRMC,";
		sentence_q.delete();
		mode = $urandom_range(0, 9);
		if (mode == 8) begin
			repeat ($urandom_range(1, 12)) sentence_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2)) sentence_q.push_back(8'($urandom_range(0, 255)));
			for (int i = 0; i < header.len(); i++) sentence_q.push_back(header[i]);
			foreach (digits[i]) digits[i] = 4'($urandom_range(0, 9));
			if ($urandom_range(0, 7) == 0) begin
				for (int i = 2; i < NUM_DIGITS; i++) digits[i] = 4'd0;
			end
			style    = $urandom_range(0, 9);
			n_digits = (style == 0 || mode == 9) ? $urandom_range(0, 5) : NUM_DIGITS;
			odd_pos  = (style == 1) ? $urandom_range(0, NUM_DIGITS - 1) : -1;
			odd_char = 8'($urandom_range(0, 255));
			if (odd_char == CHAR_COMMA) odd_char = 8'h3A;
			for (int i = 0; i < n_digits; i++) begin
				sentence_q.push_back(i == odd_pos ? odd_char : CHAR_ZERO + digits[i]);
			end
			if (style == 2) begin
				repeat ($urandom_range(1, 4))
					sentence_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
			if ($urandom_range(0, 1) == 1) begin
				sentence_q.push_back(CHAR_DOT);
				repeat ($urandom_range(0, 3))
					sentence_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
			if (mode != 9) begin
				sentence_q.push_back(CHAR_COMMA);
				repeat ($urandom_range(0, 8)) sentence_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end
		end
	endtask

	// Receiver: random stalls per stamp, none while no_gaps is set, and one long
	// hold-off on request.
	initial begin : receiver
		int wait_cycles;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				wait_cycles = RX_HOLD_CYCLES;
			end else begin
				wait_cycles = no_gaps ? 0 : $urandom_range(0, 7);
			end
			if (wait_cycles != 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("nmea_time_sentence_timestamp_top: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] now_v;
		logic [31:0] pps_v;
		int          sentence_idx;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		item_kind     = ITEM_PREDICTED;
		item_typed    = '0;
		mismatches    = 0;
		bytes_sent    = 0;
		no_gaps       = 1'b0;
		rx_hold_req   = 1'b0;
		sentence_idx  = 0;
		clear_parser();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].text.len() == 0) begin
				send_byte(directed_rows[r].raw, directed_rows[r].now, directed_rows[r].pps,
					directed_rows[r].kind, directed_rows[r].typed);
			end else begin
				for (int i = 0; i < directed_rows[r].text.len(); i++) begin
					send_byte(directed_rows[r].text[i], directed_rows[r].now,
						directed_rows[r].pps,
						(directed_rows[r].kind == ITEM_STAMPED &&
							i != directed_rows[r].text.len() - 1) ? ITEM_SILENT
							: directed_rows[r].kind,
						directed_rows[r].typed);
				end
			end
		end

		// The first sentences go out back to back while the receiver holds off,
		// so the output side fills up and stalls the input.
		rx_hold_req = 1'b1;
		while (bytes_sent < ITEM_TARGET) begin
			no_gaps = (sentence_idx < 30) || ($urandom_range(0, 5) == 0);
			build_sentence();
			foreach (sentence_q[i]) begin
				case ($urandom_range(0, 3))
					0: begin
						now_v = $urandom();
						pps_v = $urandom();
					end
					3: begin
						now_v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
						pps_v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
					end
					default: begin
						pps_v = $urandom();
						now_v = pps_v + $urandom_range(0, 999);
					end
				endcase
				send_byte(sentence_q[i], now_v, pps_v, ITEM_PREDICTED, '0);
			end
			sentence_idx++;
		end
		s_axis_tvalid <= 1'b0;
		no_gaps = 1'b0;

		while (expected_stamps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_stamps.size() != 0)
			report_mismatch("stamps never delivered", expected_stamps.size(), '0);
		if (mismatches == 0) begin
			$display("nmea_time_sentence_timestamp_top: match");
		end else begin
			$display("nmea_time_sentence_timestamp_top: mismatch");
		end
		$finish;
	end

endmodule
